// ===== design/pif_pkg.sv =====
package pif_pkg;

	// input item
	typedef struct packed {
		logic [63:0] value;
		logic [2:0]  conversion_kind;
		logic [2:0]  length_mod;
		logic [4:0]  format_flags;
		logic [6:0]  min_width;
		logic [5:0]  digit_precision;
		logic        precision_given;
	} pif_in_t;

	// result item
	typedef struct packed {
		logic [7:0] out_char;
		logic       last_char;
		logic       empty_result;
	} pif_out_t;

	// conversion codes
	localparam logic [2:0] KIND_D = 3'd0;
	localparam logic [2:0] KIND_U = 3'd1;
	localparam logic [2:0] KIND_O = 3'd2;
	localparam logic [2:0] KIND_X = 3'd3;
	localparam logic [2:0] KIND_XU = 3'd4;

	// length modifier codes
	localparam logic [2:0] MOD_NONE = 3'd0;
	localparam logic [2:0] MOD_HH = 3'd1;
	localparam logic [2:0] MOD_H = 3'd2;

	// base codes
	typedef enum logic [1:0] {
		BASE_10 = 2'd0,
		BASE_8  = 2'd1,
		BASE_16 = 2'd2
	} pif_base_t;

	localparam int MAX_DIGITS = 22;
	localparam int DIG_W = 5;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_PLUS = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;

	// classified job handed from front to back
	typedef struct packed {
		logic [63:0] mag;
		pif_base_t   base;
		logic        no_digits;
		logic        lower;
		logic        alt_oct;
		logic        pre_hex;
		logic [7:0]  sign_ch;
		logic        minus;
		logic        zero_pad;
		logic [6:0]  width;
		logic [5:0]  prec;
	} pif_job_t;

	// digit character
	function automatic logic [7:0] hex_char(input logic [3:0] d, input logic lower);
		logic [7:0] c;
		if (d < 4'd10) begin
			c = CH_ZERO + {4'd0, d};
		end else begin
			c = (lower ? 8'h61 : 8'h41) + {4'd0, d} - 8'd10;
		end
		return c;
	endfunction

endpackage

// ===== design/pif_front.sv =====
module pif_front
	import pif_pkg::*;
#(
	parameter int MAX_CHARS = 64
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  pif_in_t  in_data,
	output logic     job_valid,
	input  logic     job_ready,
	output pif_job_t job_data
);

	// two-entry queue toward the back part
	pif_job_t q_mem_q [2];
	logic     wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;
	pif_job_t job_c;

	// classify the item
	always_comb begin
		logic [2:0]  kind;
		logic [63:0] v, m;
		logic        neg;
		logic [6:0]  w;
		logic [5:0]  p;
		kind = (in_data.conversion_kind > KIND_XU) ? KIND_U : in_data.conversion_kind;
		unique case (in_data.length_mod)
			MOD_NONE: v = {32'd0, in_data.value[31:0]};
			MOD_HH:   v = {56'd0, in_data.value[7:0]};
			MOD_H:    v = {48'd0, in_data.value[15:0]};
			default:  v = in_data.value;
		endcase
		neg = 1'b0;
		if (kind == KIND_D) begin
			unique case (in_data.length_mod)
				MOD_NONE: neg = v[31];
				MOD_HH:   neg = v[7];
				MOD_H:    neg = v[15];
				default:  neg = v[63];
			endcase
		end
		m = v;
		if (neg) begin
			unique case (in_data.length_mod)
				MOD_NONE: m = {32'd0, 32'd0 - v[31:0]};
				MOD_HH:   m = {56'd0, 8'd0 - v[7:0]};
				MOD_H:    m = {48'd0, 16'd0 - v[15:0]};
				default:  m = 64'd0 - v;
			endcase
		end
		w = (in_data.min_width > 7'(MAX_CHARS)) ? 7'(MAX_CHARS) : in_data.min_width;
		p = !in_data.precision_given ? 6'd1 :
			(in_data.digit_precision > 6'(MAX_CHARS - 4)) ? 6'(MAX_CHARS - 4) :
			in_data.digit_precision;
		job_c.mag = m;
		job_c.base = (kind == KIND_O) ? BASE_8 : (kind >= KIND_X) ? BASE_16 : BASE_10;
		job_c.no_digits = (m == 64'd0) && (p == 6'd0);
		job_c.lower = (kind == KIND_X);
		job_c.alt_oct = in_data.format_flags[0] && (kind == KIND_O);
		job_c.pre_hex = in_data.format_flags[0] && (kind >= KIND_X) && (m != 64'd0);
		job_c.sign_ch = 8'd0;
		if (kind == KIND_D) begin
			job_c.sign_ch = neg ? CH_MINUS : in_data.format_flags[3] ? CH_PLUS :
				in_data.format_flags[4] ? CH_SPACE : 8'd0;
		end
		job_c.minus = in_data.format_flags[2];
		job_c.zero_pad = in_data.format_flags[1] && !in_data.precision_given;
		job_c.width = w;
		job_c.prec = p;
	end

	assign in_ready = (cnt_q != 2'd2);
	assign job_valid = (cnt_q != 2'd0);
	assign job_data = q_mem_q[rd_ptr_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			q_mem_q[wr_ptr_q] <= job_c;
		end
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (in_valid && in_ready) wr_ptr_q <= ~wr_ptr_q;
			if (job_valid && job_ready) rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + {1'b0, in_valid && in_ready} - {1'b0, job_valid && job_ready};
		end
	end

endmodule

// ===== design/pif_back.sv =====
module pif_back
	import pif_pkg::*;
#(
	parameter int MAX_CHARS = 64
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     job_valid,
	output logic     job_ready,
	input  pif_job_t job_data,
	output logic     out_valid,
	input  logic     out_ready,
	output pif_out_t out_data
);

	localparam int CW = 7;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_DIV  = 4'b0010,
		ST_PLAN = 4'b0100,
		ST_EMIT = 4'b1000
	} st_t;

	st_t        st_q;
	pif_job_t   job_q;
	logic [63:0] quo_q;
	logic [3:0] dig_q [MAX_DIGITS];
	logic [DIG_W-1:0] nd_q;
	logic [6:0] zeros_q, pad_q, len_q, pos_q;
	logic       sgn_q;
	logic       empty_q;
	logic [1:0] part_q;
	logic [3:0] rem_q;

	// one digit step: octal and hex by shifting, decimal one 16-bit slice per cycle
	logic [63:0] q_c;
	logic [3:0]  r_c;
	logic        digit_done;
	always_comb begin
		logic [19:0] dx;
		logic [39:0] dp;
		logic [15:0] dq;
		logic [19:0] dr;
		dx = {rem_q, quo_q[{part_q, 4'd0} +: 16]};
		dp = dx * 20'd838861;
		dq = dp[38:23];
		dr = dx - {4'd0, dq} * 20'd10;
		q_c = quo_q;
		r_c = 4'd0;
		digit_done = 1'b1;
		unique case (job_q.base)
			BASE_8: begin
				q_c = quo_q >> 3;
				r_c = {1'b0, quo_q[2:0]};
			end
			BASE_16: begin
				q_c = quo_q >> 4;
				r_c = quo_q[3:0];
			end
			default: begin
				q_c[{part_q, 4'd0} +: 16] = dq;
				r_c = dr[3:0];
				digit_done = (part_q == 2'd0);
			end
		endcase
	end

	// plan counts
	logic [6:0] zeros_c, body_c, pad_c;
	always_comb begin
		logic [6:0] z;
		logic [6:0] ndw;
		ndw = {{(7-DIG_W){1'b0}}, nd_q};
		z = ({1'b0, job_q.prec} > ndw) ? {1'b0, job_q.prec} - ndw : 7'd0;
		if (job_q.alt_oct && !(z != 7'd0 || (nd_q != '0 && dig_q[nd_q - 1'b1] == 4'd0))) begin
			z = z + 7'd1;
		end
		zeros_c = z;
		body_c = z + ndw + {6'd0, job_q.sign_ch != 8'd0} + (job_q.pre_hex ? 7'd2 : 7'd0);
		pad_c = (job_q.width > body_c) ? job_q.width - body_c : 7'd0;
		if (body_c + pad_c > CW'(MAX_CHARS)) begin
			pad_c = (body_c < CW'(MAX_CHARS)) ? CW'(MAX_CHARS) - body_c : 7'd0;
		end
	end

	// character at the current position
	logic [7:0] ch_c;
	always_comb begin
		logic [6:0] k;
		logic [6:0] lp, sp, pp, zp, zz;
		lp = (!job_q.minus && !job_q.zero_pad) ? pad_q : 7'd0;
		sp = lp + {6'd0, sgn_q};
		pp = sp + (job_q.pre_hex ? 7'd2 : 7'd0);
		zp = pp + ((!job_q.minus && job_q.zero_pad) ? pad_q : 7'd0);
		zz = zp + zeros_q;
		k = 7'd0;
		if (pos_q < lp) ch_c = CH_SPACE;
		else if (pos_q < sp) ch_c = job_q.sign_ch;
		else if (pos_q == sp && job_q.pre_hex) ch_c = CH_ZERO;
		else if (pos_q < pp) ch_c = job_q.lower ? 8'h78 : 8'h58;
		else if (pos_q < zz) ch_c = CH_ZERO;
		else if (pos_q < zz + {{(7-DIG_W){1'b0}}, nd_q}) begin
			k = zz + {{(7-DIG_W){1'b0}}, nd_q} - 7'd1 - pos_q;
			ch_c = hex_char(dig_q[k[DIG_W-1:0]], job_q.lower);
		end else ch_c = CH_SPACE;
	end

	// output register
	logic ov_q;
	pif_out_t od_q;
	assign out_valid = ov_q;
	assign out_data = od_q;
	logic emit_go;
	assign emit_go = (st_q == ST_EMIT) && (!ov_q || out_ready);
	assign job_ready = (st_q == ST_IDLE);

	always_ff @(posedge clk) begin
		if (job_valid && job_ready) begin
			job_q <= job_data;
			quo_q <= job_data.mag;
		end else if (st_q == ST_DIV) begin
			if (digit_done) dig_q[nd_q] <= r_c;
			quo_q <= q_c;
		end
		if (st_q == ST_PLAN) begin
			zeros_q <= zeros_c;
			pad_q <= pad_c;
			sgn_q <= job_q.sign_ch != 8'd0;
			len_q <= body_c + pad_c;
			empty_q <= (body_c + pad_c) == 7'd0;
		end
		if (emit_go) begin
			od_q.out_char <= empty_q ? 8'd0 : ch_c;
			od_q.last_char <= empty_q || (pos_q + 7'd1 == len_q);
			od_q.empty_result <= empty_q;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			nd_q <= '0;
			pos_q <= 7'd0;
			ov_q <= 1'b0;
			part_q <= 2'd3;
			rem_q <= 4'd0;
		end else begin
			ov_q <= emit_go || (ov_q && !out_ready);
			unique case (st_q)
				ST_IDLE: begin
					if (job_valid) begin
						nd_q <= '0;
						part_q <= 2'd3;
						rem_q <= 4'd0;
						st_q <= job_data.no_digits ? ST_PLAN : ST_DIV;
					end
				end
				ST_DIV: begin
					part_q <= part_q - 2'd1;
					rem_q <= digit_done ? 4'd0 : r_c;
					if (digit_done) begin
						nd_q <= nd_q + 1'b1;
						if (q_c == 64'd0) st_q <= ST_PLAN;
					end
				end
				ST_PLAN: begin
					pos_q <= 7'd0;
					st_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (emit_go) begin
						pos_q <= pos_q + 7'd1;
						if (empty_q || pos_q + 7'd1 == len_q) st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== design/printf_integer_formatter.sv =====
// printf_integer_formatter: formats one integer as %d/%u/%o/%x/%X would.
// input channel: in_valid/in_ready with in_data (pif_in_t); one item is one
//   value plus its conversion spec.
// output channel: out_valid/out_ready with out_data (pif_out_t); one item per
//   formatted character, last_char marks the end. An empty text gives a
//   single item with empty_result and last_char set.
// a front part classifies each item (truncation, sign, saturation) and puts it
// in a two-entry queue; the back part extracts digits and then emits one
// character per cycle through an output register while the receiver is ready.
// per item: a start step, then digit extraction (up to 22 digits for octal,
// up to 20 for decimal), a planning step, then one step per character (up
// to MAX_CHARS). when the back part is idle, the first character follows
// acceptance through the queue, digit extraction, planning and the output
// register.
// a stalled receiver holds the current character; the queue keeps taking
// items until full. reset empties the queue and the back part.
module printf_integer_formatter
	import pif_pkg::*;
#(
	parameter int MAX_CHARS = 64
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  pif_in_t  in_data,
	output logic     out_valid,
	input  logic     out_ready,
	output pif_out_t out_data
);

	logic     job_valid, job_ready;
	pif_job_t job_data;

	pif_front #(.MAX_CHARS(MAX_CHARS)) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.job_valid(job_valid), .job_ready(job_ready), .job_data(job_data)
	);

	pif_back #(.MAX_CHARS(MAX_CHARS)) u_back (
		.clk(clk), .arst_n(arst_n),
		.job_valid(job_valid), .job_ready(job_ready), .job_data(job_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	// an empty result is always a single last item
	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.empty_result |-> out_data.last_char)
		else $error("empty item not marked last");

	// an empty item carries a zero character
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.empty_result |-> out_data.out_char == 8'd0)
		else $error("empty item with character");

	// back part stays idle while the queue offers no job
	a_job_hs: assert property (@(posedge clk) disable iff (!arst_n)
		job_ready && !job_valid |=> job_ready)
		else $error("back part left idle without a job");

endmodule
